// ----- rtl/bfsa_pkg.sv -----
// Shared types and constants for the best-fit segment allocator.
package bfsa_pkg;
    localparam int FREE_ENTRIES = 16;
    localparam int IDX_BITS     = $clog2(FREE_ENTRIES);
    localparam int CNT_BITS     = $clog2(FREE_ENTRIES + 1);
    localparam int ADDR_BITS    = 32;
    localparam int SIZE_BITS    = 24;
    localparam int HEADER_BYTES = 24;

    localparam logic [ADDR_BITS-1:0] HDR_A = ADDR_BITS'(HEADER_BYTES);
    localparam logic [SIZE_BITS:0]   HDR_S = (SIZE_BITS+1)'(HEADER_BYTES);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NULL = 2'd3;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // one table entry: header address and payload size
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_BITS-1:0] size;
    } t_seg;
endpackage

// ----- rtl/bfsa_seg_ram.sv -----
// Free segment table memory: one write port, one registered read port.
module bfsa_seg_ram
    import bfsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [IDX_BITS-1:0] i_waddr,
    input  t_seg                i_wdata,
    input  logic [IDX_BITS-1:0] i_raddr,
    output t_seg                o_rdata
);
    t_seg mem [FREE_ENTRIES];
    t_seg r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/best_fit_segment_allocator.sv -----
// Top level of the best-fit segment allocator engine.
// One item at a time. The free table sits in a memory with one read port, which is
// registered. An allocate scans all valid entries, decides in S_ADEC and finishes in
// S_DONE; taking a whole segment adds a shift-down of the entries above it. A free
// with a null address or a full table goes straight to S_DONE; any other free walks
// the table to its slot and shifts the upper entries up, then inserts, checks the
// following neighbor and the preceding one, and shifts entries down for each
// neighbor that is absorbed. The result moves to an output register when it is done,
// so a new item is taken while a result waits; a finished item stalls only while the
// previous result is still unaccepted.
module best_fit_segment_allocator
    import bfsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [23:0] req_size, [55:24] block_addr, [79:56] block_size
    input  logic [79:0] s_axis_tdata,
    // [0] func
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [33:2] payload_addr, [57:34] granted_size,
    // [89:58] segment_total, [121:90] free_total
    output logic [127:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SCAN  = 11'b00000000010,
        S_ADEC  = 11'b00000000100,
        S_DROP  = 11'b00000001000,
        S_FIND  = 11'b00000010000,
        S_SHUP  = 11'b00000100000,
        S_INS   = 11'b00001000000,
        S_MNXT  = 11'b00010000000,
        S_MPRV  = 11'b00100000000,
        S_MDEC  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [31:0] r_limit, r_brk, r_grown, r_freed;
    logic [CNT_BITS-1:0] r_count;
    logic        r_func;
    logic [SIZE_BITS-1:0] r_req, r_bsize;
    logic [ADDR_BITS-1:0] r_hdr;
    logic [CNT_BITS-1:0] r_ptr;      // address issued this cycle
    logic [CNT_BITS-1:0] r_rptr;     // index of data arriving now
    logic        r_rvalid;
    logic        r_found;
    logic [IDX_BITS-1:0] r_best;
    t_seg        r_bseg;
    logic [CNT_BITS-1:0] r_pos;
    t_seg        r_prev;             // entry below insert point
    logic        r_has_prev;
    logic        r_mprev_after;      // after next-merge, still try previous
    logic        r_ovalid;
    logic [121:0] r_odata;
    logic [1:0]  r_st;
    logic [31:0] r_pay;
    logic [23:0] r_gnt;

    logic        ram_we;
    logic [IDX_BITS-1:0] ram_waddr, ram_raddr;
    t_seg        ram_wdata, rd;

    bfsa_seg_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(rd)
    );

    wire in_acc  = s_axis_tvalid && s_axis_tready;
    wire out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_odata};

    // growth path arithmetic
    wire [SIZE_BITS:0] need = {1'b0, r_req} + HDR_S;
    wire [32:0] nb = {1'b0, r_brk} + 33'(need);
    wire oom = nb[32] || (nb[31:0] > r_limit);

    // merge checks for the arriving next entry and the stored previous entry
    wire [25:0] msum_nxt = 26'(r_bsize) + 26'(rd.size) + 26'(HEADER_BYTES);
    wire nxt_adj = (r_hdr + 32'(r_bsize) + HDR_A) == rd.start;
    wire [25:0] msum_prv = 26'(r_prev.size) + 26'(r_bsize) + 26'(HEADER_BYTES);
    wire prv_adj = (r_prev.start + 32'(r_prev.size) + HDR_A) == r_hdr;

    always_comb begin
        ram_raddr = r_ptr[IDX_BITS-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_rptr[IDX_BITS-1:0];
        ram_wdata = rd;
        unique case (r_state)
            S_SHUP: begin
                ram_we    = r_rvalid;
                ram_waddr = IDX_BITS'(r_rptr + 1'b1);
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[IDX_BITS-1:0];
                ram_wdata = '{start: r_hdr, size: r_bsize};
            end
            S_MDEC: begin
                ram_we    = r_rvalid;
                ram_waddr = IDX_BITS'(r_rptr - 1'b1);
            end
            S_ADEC: begin
                ram_we    = r_found && r_bseg.size >= need[SIZE_BITS-1:0] && !need[SIZE_BITS];
                ram_waddr = r_best;
                ram_wdata = '{start: r_bseg.start,
                              size: SIZE_BITS'(r_bseg.size - need[SIZE_BITS-1:0])};
            end
            S_DONE: begin
                // write back a merged entry
                ram_we    = r_rvalid;
                ram_waddr = r_pos[IDX_BITS-1:0];
                ram_wdata = '{start: r_hdr, size: r_bsize};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= 32'd1048576;
            r_brk    <= 32'd4096;
            r_grown  <= '0;
            r_freed  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            if (out_acc) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BASE:  r_brk   <= i_cfg_data;
                    CFG_LIMIT: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            r_rvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_acc) begin
                    r_func  <= s_axis_tuser;
                    r_req   <= s_axis_tdata[23:0];
                    r_hdr   <= s_axis_tdata[55:24] - HDR_A;
                    r_bsize <= s_axis_tdata[79:56];
                    r_pay   <= '0;
                    r_gnt   <= '0;
                    r_found <= 1'b0;
                    r_ptr   <= '0;
                    r_has_prev <= 1'b0;
                    if (s_axis_tuser == FN_ALLOC) begin
                        r_st <= ST_OK; r_state <= S_SCAN;
                    end else if (s_axis_tdata[55:24] == 32'd0) begin
                        r_st <= ST_NULL; r_state <= S_DONE;
                    end else if (r_count == CNT_BITS'(FREE_ENTRIES)) begin
                        r_st <= ST_FULL; r_state <= S_DONE;
                    end else begin
                        r_st <= ST_OK; r_state <= S_FIND;
                    end
                end
                S_SCAN: begin
                    if (r_ptr < r_count) begin
                        r_ptr <= r_ptr + 1'b1; r_rvalid <= 1'b1; r_rptr <= r_ptr;
                    end
                    if (r_rvalid && rd.size >= r_req && (!r_found || rd.size < r_bseg.size)) begin
                        r_found <= 1'b1;
                        r_best  <= r_rptr[IDX_BITS-1:0];
                        r_bseg  <= rd;
                    end
                    if (!r_rvalid && r_ptr >= r_count) r_state <= S_ADEC;
                end
                S_ADEC: begin
                    r_state <= S_DONE;
                    if (!r_found) begin
                        if (oom) r_st <= ST_OOM;
                        else begin
                            r_pay   <= r_brk + HDR_A;
                            r_gnt   <= r_req;
                            r_brk   <= nb[31:0];
                            r_grown <= r_grown + 32'(need);
                        end
                    end else if (need[SIZE_BITS] || r_bseg.size < need[SIZE_BITS-1:0]) begin
                        r_pay   <= r_bseg.start + HDR_A;
                        r_gnt   <= r_bseg.size;
                        r_freed <= r_freed - 32'(r_bseg.size) - HDR_A;
                        r_ptr   <= CNT_BITS'(r_best) + 1'b1;
                        r_mprev_after <= 1'b0;
                        r_state <= S_MDEC;
                    end else begin
                        r_pay   <= r_bseg.start + HDR_A + 32'(SIZE_BITS'(r_bseg.size -
                                   need[SIZE_BITS-1:0])) + HDR_A;
                        r_gnt   <= r_req;
                        r_freed <= r_freed - 32'(need);
                    end
                end
                S_FIND: begin
                    // linear walk until first start > hdr
                    if (r_rvalid) begin
                        if (rd.start <= r_hdr) begin
                            r_prev <= rd; r_has_prev <= 1'b1;
                        end else begin
                            r_pos <= r_rptr;
                            r_ptr <= r_count - 1'b1;
                            r_state <= S_SHUP;
                        end
                    end
                    if (r_state == S_FIND && !(r_rvalid && rd.start > r_hdr)) begin
                        if (r_ptr < r_count && !r_rvalid) begin
                            r_rvalid <= 1'b1; r_rptr <= r_ptr; r_ptr <= r_ptr + 1'b1;
                        end else if (!r_rvalid) begin
                            r_pos <= r_count; r_state <= S_INS;
                        end
                    end
                end
                S_SHUP: begin
                    // read r_ptr downward, write to r_ptr+1
                    if (!r_rvalid) begin
                        r_rvalid <= 1'b1; r_rptr <= r_ptr;
                        if (r_ptr != r_pos) r_ptr <= r_ptr - 1'b1;
                    end else if (r_rptr == r_pos) begin
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    r_count <= r_count + 1'b1;
                    r_freed <= r_freed + 32'(r_bsize) + HDR_A;
                    r_ptr   <= r_pos + 1'b1;
                    r_state <= S_MNXT;
                end
                S_MNXT: begin
                    if (!r_rvalid && r_ptr < r_count) begin
                        r_rvalid <= 1'b1; r_rptr <= r_ptr;
                    end else begin
                        r_state <= S_MPRV;
                        if (r_rvalid && nxt_adj && msum_nxt <= 26'hFFFFFF) begin
                            r_bsize <= msum_nxt[23:0];
                            r_ptr   <= r_ptr + 1'b1;
                            r_mprev_after <= 1'b1;
                            r_state <= S_MDEC;
                        end
                    end
                end
                S_MPRV: begin
                    r_mprev_after <= 1'b0;
                    if (r_has_prev && prv_adj && msum_prv <= 26'hFFFFFF) begin
                        r_hdr   <= r_prev.start;
                        r_bsize <= msum_prv[23:0];
                        r_pos   <= r_pos - 1'b1;
                        r_ptr   <= r_pos + 1'b1;
                        r_state <= S_MDEC;
                    end else begin
                        r_rvalid <= 1'b1; // write back merged current
                        r_state  <= S_DONE;
                    end
                end
                S_MDEC: begin
                    // shift entries above the removed one down by one
                    if (!r_rvalid && r_ptr < r_count) begin
                        r_rvalid <= 1'b1; r_rptr <= r_ptr; r_ptr <= r_ptr + 1'b1;
                    end else if (!r_rvalid) begin
                        r_count <= r_count - 1'b1;
                        if (r_mprev_after) r_state <= S_MPRV;
                        else if (r_func == FN_FREE) begin
                            r_rvalid <= 1'b1; r_state <= S_DONE;
                        end else r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || out_acc) begin
                        r_odata  <= {r_freed, r_grown, r_gnt, r_pay, r_st};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
